[rtl/zrbd_pkg.sv]
// ----------------------------------------------------------------------------
// zrbd_pkg
// Shared constants for the zero-run bit stream decompressor.
// ----------------------------------------------------------------------------
package zrbd_pkg;

  localparam int unsigned StatusW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 23;
  localparam int unsigned LenW    = 6;
  localparam int unsigned FbW     = 5;

  localparam logic [StatusW-1:0] StByte   = 3'd0;
  localparam logic [StatusW-1:0] StNeed   = 3'd1;
  localparam logic [StatusW-1:0] StDone   = 3'd2;
  localparam logic [StatusW-1:0] StMagic  = 3'd3;
  localparam logic [StatusW-1:0] StAccept = 3'd4;
  localparam logic [StatusW-1:0] StReject = 3'd5;

  localparam logic OpPush = 1'b0;
  localparam logic OpPull = 1'b1;

  localparam logic [63:0] Magic = {32'h49434543, 32'h4f4d5052};

  // Field width that follows a prefix ending at the given bit position.
  function automatic logic [FbW-1:0] field_width(input logic [2:0] pos);
    logic [FbW-1:0] w;
    case (pos)
      3'd0:    w = 5'd2;
      3'd1:    w = 5'd5;
      3'd2:    w = 5'd8;
      3'd3:    w = 5'd6;
      default: w = 5'd23;
    endcase
    return w;
  endfunction

endpackage

[rtl/zero_run_bitstream_decompressor_core.sv]
// A push word answers in the cycle after it is accepted.
// A pull word runs one decode step after another until it answers; a step
// takes at most one input bit and gives at most one output bit, so a pull ends
// within 16 steps. One word is in flight at a time; a new word is taken as the
// result is read. Reset is asynchronous and active low and returns the decoder
// to the start of the magic header with an empty input buffer.
// ----------------------------------------------------------------------------
// zero_run_bitstream_decompressor_core
// Bit-serial decoder for a prefix-coded zero-run stream with a magic header.
// ----------------------------------------------------------------------------
module zero_run_bitstream_decompressor_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] out_byte_o
);

  typedef enum logic {
    S_IDLE,
    S_DECODE
  } state_e;

  typedef enum logic [3:0] {
    P_PRE0,
    P_PRE1,
    P_PRE2,
    P_PRE3,
    P_PRE4,
    P_FRUN,
    P_FFINAL,
    P_FLIT,
    P_LITERAL,
    P_EMIT,
    P_EMIT_FINAL
  } phase_e;

  state_e                           state_q, state_d;
  phase_e                           phase_q, phase_d;
  logic [7:0]                       in_shift_q, in_shift_d;
  logic [3:0]                       in_count_q, in_count_d;
  logic [6:0]                       header_count_q, header_count_d;
  logic                             header_match_q, header_match_d;
  logic [zrbd_pkg::FbW-1:0]         fbl_q, fbl_d;
  logic [zrbd_pkg::CountW-1:0]      field_q, field_d;
  logic [zrbd_pkg::CountW-1:0]      pending_q, pending_d;
  logic [zrbd_pkg::LenW-1:0]        lit_left_q, lit_left_d;
  logic [7:0]                       out_shift_q, out_shift_d;
  logic [3:0]                       out_count_q, out_count_d;
  logic                             finished_q, finished_d;
  logic                             bad_magic_q, bad_magic_d;
  logic                             out_valid_q, out_valid_d;
  logic [zrbd_pkg::StatusW-1:0]     status_q, status_d;
  logic [7:0]                       out_byte_q, out_byte_d;

  logic       have_bit;
  logic [2:0] bit_idx;
  logic       cur_bit;
  logic       exp_bit;
  logic       in_fire;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_byte_o  = out_byte_q;

  assign have_bit = (in_count_q != 4'd0);
  assign bit_idx  = in_count_q[2:0] - 3'd1;
  assign cur_bit  = in_shift_q[bit_idx];
  assign exp_bit  = zrbd_pkg::Magic[6'd63 - header_count_q[5:0]];

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    in_shift_d     = in_shift_q;
    in_count_d     = in_count_q;
    header_count_d = header_count_q;
    header_match_d = header_match_q;
    fbl_d          = fbl_q;
    field_d        = field_q;
    pending_d      = pending_q;
    lit_left_d     = lit_left_q;
    out_shift_d    = out_shift_q;
    out_count_d    = out_count_q;
    finished_d     = finished_q;
    bad_magic_d    = bad_magic_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    status_d       = status_q;
    out_byte_d     = out_byte_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (opcode_i == zrbd_pkg::OpPush) begin
            out_valid_d = 1'b1;
            out_byte_d  = 8'd0;
            if (have_bit) begin
              status_d = zrbd_pkg::StReject;
            end else begin
              status_d   = zrbd_pkg::StAccept;
              in_shift_d = in_byte_i;
              in_count_d = 4'd8;
            end
          end else if (bad_magic_q) begin
            out_valid_d = 1'b1;
            out_byte_d  = 8'd0;
            status_d    = zrbd_pkg::StMagic;
          end else if (finished_q) begin
            out_valid_d = 1'b1;
            out_byte_d  = 8'd0;
            status_d    = zrbd_pkg::StDone;
          end else begin
            state_d = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        if (!header_count_q[6]) begin
          if (!have_bit) begin
            state_d     = S_IDLE;
            out_valid_d = 1'b1;
            status_d    = zrbd_pkg::StNeed;
            out_byte_d  = 8'd0;
          end else begin
            in_count_d     = in_count_q - 4'd1;
            header_count_d = header_count_q + 7'd1;
            header_match_d = header_match_q && (cur_bit == exp_bit);
            if (header_count_q == 7'd63 && !header_match_d) begin
              bad_magic_d = 1'b1;
              state_d     = S_IDLE;
              out_valid_d = 1'b1;
              status_d    = zrbd_pkg::StMagic;
              out_byte_d  = 8'd0;
            end
          end
        end else begin
          case (phase_q)
            P_PRE0, P_PRE1, P_PRE2, P_PRE3, P_PRE4: begin
              if (!have_bit) begin
                state_d     = S_IDLE;
                out_valid_d = 1'b1;
                status_d    = zrbd_pkg::StNeed;
                out_byte_d  = 8'd0;
              end else begin
                in_count_d = in_count_q - 4'd1;
                field_d    = '0;
                if (cur_bit) begin
                  fbl_d   = zrbd_pkg::field_width(phase_q[2:0]);
                  phase_d = (phase_q == P_PRE3) ? P_FLIT : P_FRUN;
                end else if (phase_q == P_PRE4) begin
                  fbl_d   = 5'd23;
                  phase_d = P_FFINAL;
                end else begin
                  phase_d = phase_e'(phase_q + 4'd1);
                end
              end
            end
            P_FRUN, P_FFINAL, P_FLIT: begin
              if (!have_bit) begin
                state_d     = S_IDLE;
                out_valid_d = 1'b1;
                status_d    = zrbd_pkg::StNeed;
                out_byte_d  = 8'd0;
              end else begin
                in_count_d = in_count_q - 4'd1;
                field_d    = {field_q[zrbd_pkg::CountW-2:0], cur_bit};
                fbl_d      = fbl_q - 5'd1;
                if (fbl_q == 5'd1) begin
                  if (phase_q == P_FLIT) begin
                    lit_left_d = field_d[zrbd_pkg::LenW-1:0];
                    phase_d    = P_LITERAL;
                  end else begin
                    pending_d = field_d;
                    phase_d   = (phase_q == P_FRUN) ? P_EMIT : P_EMIT_FINAL;
                  end
                end
              end
            end
            P_LITERAL: begin
              if (lit_left_q != '0) begin
                if (!have_bit) begin
                  state_d     = S_IDLE;
                  out_valid_d = 1'b1;
                  status_d    = zrbd_pkg::StNeed;
                  out_byte_d  = 8'd0;
                end else begin
                  in_count_d  = in_count_q - 4'd1;
                  out_shift_d = {out_shift_q[6:0], cur_bit};
                  out_count_d = out_count_q + 4'd1;
                  lit_left_d  = lit_left_q - 6'd1;
                end
              end else begin
                out_shift_d = {out_shift_q[6:0], 1'b1};
                out_count_d = out_count_q + 4'd1;
                phase_d     = P_PRE0;
              end
            end
            P_EMIT: begin
              out_count_d = out_count_q + 4'd1;
              if (pending_q != '0) begin
                out_shift_d = {out_shift_q[6:0], 1'b0};
                pending_d   = pending_q - 23'd1;
              end else begin
                out_shift_d = {out_shift_q[6:0], 1'b1};
                phase_d     = P_PRE0;
              end
            end
            P_EMIT_FINAL: begin
              if (pending_q != '0) begin
                out_shift_d = {out_shift_q[6:0], 1'b0};
                out_count_d = out_count_q + 4'd1;
                pending_d   = pending_q - 23'd1;
                if (pending_q == 23'd1 && out_count_d == 4'd8) begin
                  finished_d = 1'b1;
                end
              end else begin
                finished_d  = 1'b1;
                state_d     = S_IDLE;
                out_valid_d = 1'b1;
                status_d    = zrbd_pkg::StDone;
                out_byte_d  = 8'd0;
              end
            end
            default: begin
              phase_d = P_PRE0;
            end
          endcase
          if (out_count_d[3]) begin
            state_d     = S_IDLE;
            out_valid_d = 1'b1;
            status_d    = zrbd_pkg::StByte;
            out_byte_d  = out_shift_d;
            out_shift_d = 8'd0;
            out_count_d = 4'd0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      phase_q        <= P_PRE0;
      in_shift_q     <= 8'd0;
      in_count_q     <= 4'd0;
      header_count_q <= 7'd0;
      header_match_q <= 1'b1;
      fbl_q          <= '0;
      field_q        <= '0;
      pending_q      <= '0;
      lit_left_q     <= '0;
      out_shift_q    <= 8'd0;
      out_count_q    <= 4'd0;
      finished_q     <= 1'b0;
      bad_magic_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      status_q       <= zrbd_pkg::StByte;
      out_byte_q     <= 8'd0;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      in_shift_q     <= in_shift_d;
      in_count_q     <= in_count_d;
      header_count_q <= header_count_d;
      header_match_q <= header_match_d;
      fbl_q          <= fbl_d;
      field_q        <= field_d;
      pending_q      <= pending_d;
      lit_left_q     <= lit_left_d;
      out_shift_q    <= out_shift_d;
      out_count_q    <= out_count_d;
      finished_q     <= finished_d;
      bad_magic_q    <= bad_magic_d;
      out_valid_q    <= out_valid_d;
      status_q       <= status_d;
      out_byte_q     <= out_byte_d;
    end
  end

`ifndef SYNTH
  a_in_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_count_q <= 4'd8)
    else $error("Input bit count exceeds one byte.");

  a_out_count_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_count_q < 4'd8)
    else $error("A complete output byte was left unflushed.");

  a_decode_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECODE |-> !out_valid_q)
    else $error("Decoding while a result is still pending.");

  a_bad_magic_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_magic_q |-> (header_count_q == 7'd64 && !header_match_q))
    else $error("Bad magic flagged before the header completed.");
`endif

endmodule

[test/zero_run_bitstream_decompressor_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_run_bitstream_decompressor_core_test
// Feeds one compressed stream, header first, through push and pull words with
// random sender gaps and receiver stalls. Every answer is checked against a fixed
// value or a bit-level decoder kept alongside, and the stream closes with a final run.
// ----------------------------------------------------------------------------
module zero_run_bitstream_decompressor_core_test;

  typedef enum logic [2:0] {
    PhPrefix, PhRunField, PhFinalField, PhLenField, PhLiteral, PhRunOut, PhFinalOut
  } phase_e;

  typedef struct packed {
    logic [zrbd_pkg::StatusW-1:0] status;
    logic [zrbd_pkg::ByteW-1:0]   data;
  } answer_t;

  typedef struct packed {
    logic                         op;
    logic [zrbd_pkg::ByteW-1:0]   data;
    logic                         typed;
    logic [zrbd_pkg::StatusW-1:0] status;
    logic [zrbd_pkg::ByteW-1:0]   out;
  } row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       opcode_i    = zrbd_pkg::OpPush;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] status_o;
  logic [7:0] out_byte_o;

  zero_run_bitstream_decompressor_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .out_byte_o (out_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder state, starting from its reset values.
  logic [7:0]                  buf_bits    = '0;
  int unsigned                 buf_left    = 0;
  int unsigned                 hdr_pos     = 0;
  logic                        hdr_ok      = 1'b1;
  phase_e                      phase       = PhPrefix;
  int unsigned                 pre_pos     = 0;
  int unsigned                 fld_left    = 0;
  logic [zrbd_pkg::CountW-1:0] fld_val     = '0;
  logic [zrbd_pkg::CountW-1:0] zeros_left  = '0;
  logic [zrbd_pkg::LenW-1:0]   lit_left    = '0;
  logic [7:0]                  obuf        = '0;
  int unsigned                 obuf_n      = 0;
  logic                        stream_done = 1'b0;
  logic                        magic_bad   = 1'b0;

  answer_t     want_q[$];
  answer_t     head;
  logic        code_bits[$];
  int unsigned out_bits    = 0;
  int unsigned burst_left  = 0;
  int unsigned words_read  = 0;
  int unsigned errs        = 0;

  function automatic logic pop_bit();
    buf_left--;
    return buf_bits[buf_left];
  endfunction

  function automatic void push_out(logic bt);
    obuf = {obuf[6:0], bt};
    obuf_n++;
  endfunction

  function automatic answer_t decode_word(logic op, logic [7:0] data);
    answer_t a;
    a = '{status: zrbd_pkg::StByte, data: 8'h00};
    if (op == zrbd_pkg::OpPush) begin
      if (buf_left != 0) begin
        a.status = zrbd_pkg::StReject;
      end else begin
        buf_bits = data;
        buf_left = 8;
        a.status = zrbd_pkg::StAccept;
      end
      return a;
    end
    if (magic_bad) begin
      a.status = zrbd_pkg::StMagic;
      return a;
    end
    if (stream_done) begin
      a.status = zrbd_pkg::StDone;
      return a;
    end
    while (1'b1) begin
      if (buf_left == 0 && (hdr_pos < 64 ||
          phase inside {PhPrefix, PhRunField, PhFinalField, PhLenField} ||
          (phase == PhLiteral && lit_left != 0))) begin
        a.status = zrbd_pkg::StNeed;
        return a;
      end
      if (hdr_pos < 64) begin
        if (pop_bit() != zrbd_pkg::Magic[63 - hdr_pos]) hdr_ok = 1'b0;
        hdr_pos++;
        if (hdr_pos == 64 && !hdr_ok) begin
          magic_bad = 1'b1;
          a.status = zrbd_pkg::StMagic;
          return a;
        end
      end else begin
        case (phase)
          PhPrefix: begin
            fld_val = '0;
            if (pop_bit()) begin
              case (pre_pos)
                0: fld_left = 2;
                1: fld_left = 5;
                2: fld_left = 8;
                3: fld_left = zrbd_pkg::LenW;
                default: fld_left = zrbd_pkg::CountW;
              endcase
              phase = (pre_pos == 3) ? PhLenField : PhRunField;
              pre_pos = 0;
            end else if (pre_pos == 4) begin
              fld_left = zrbd_pkg::CountW;
              phase = PhFinalField;
              pre_pos = 0;
            end else begin
              pre_pos++;
            end
          end
          PhRunField, PhFinalField, PhLenField: begin
            fld_val = {fld_val[zrbd_pkg::CountW-2:0], pop_bit()};
            fld_left--;
            if (fld_left == 0) begin
              if (phase == PhLenField) begin
                lit_left = fld_val[zrbd_pkg::LenW-1:0];
                phase = PhLiteral;
              end else begin
                zeros_left = fld_val;
                phase = (phase == PhRunField) ? PhRunOut : PhFinalOut;
              end
            end
          end
          PhLiteral: begin
            if (lit_left != 0) begin
              push_out(pop_bit());
              lit_left--;
            end else begin
              push_out(1'b1);
              phase = PhPrefix;
            end
          end
          PhRunOut: begin
            if (zeros_left != 0) begin
              push_out(1'b0);
              zeros_left--;
            end else begin
              push_out(1'b1);
              phase = PhPrefix;
            end
          end
          default: begin
            if (zeros_left == 0) begin
              stream_done = 1'b1;
              a.status = zrbd_pkg::StDone;
              return a;
            end
            push_out(1'b0);
            zeros_left--;
            if (zeros_left == 0 && obuf_n == 8) begin
              stream_done = 1'b1;
              a.data = obuf;
              obuf = '0;
              obuf_n = 0;
              return a;
            end
          end
        endcase
      end
      if (obuf_n >= 8) begin
        a.data = obuf;
        obuf = '0;
        obuf_n = 0;
        return a;
      end
    end
    return a;
  endfunction

  function automatic void add_bits(int unsigned v, int unsigned w);
    for (int i = int'(w) - 1; i >= 0; i--) code_bits.push_back(v[i]);
  endfunction

  // Appends one random token and keeps count of the output bits it yields.
  function automatic void add_token();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = $urandom_range(0, 3);
      add_bits(1, 1);
      add_bits(n, 2);
    end else if (pick < 60) begin
      n = $urandom_range(0, 31);
      add_bits(1, 2);
      add_bits(n, 5);
    end else if (pick < 70) begin
      n = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
      add_bits(1, 3);
      add_bits(n, 8);
    end else if (pick < 90) begin
      case ($urandom_range(0, 4))
        0: n = 0;
        1: n = 63;
        default: n = $urandom_range(1, 62);
      endcase
      add_bits(1, 4);
      add_bits(n, zrbd_pkg::LenW);
      repeat (n) add_bits($urandom_range(0, 1), 1);
    end else begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 40);
      add_bits(1, 5);
      add_bits(n, zrbd_pkg::CountW);
    end
    out_bits += n + 1;
  endfunction

  function automatic logic [7:0] next_stream_byte();
    logic [7:0] b;
    while (code_bits.size() < 8) add_token();
    for (int i = 7; i >= 0; i--) b[i] = code_bits.pop_front();
    return b;
  endfunction

  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic put_word(input logic op, input logic [7:0] data, input logic typed,
                          input answer_t ans);
    answer_t got;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    in_byte_i  <= data;
    do @(posedge clk_i); while (!in_ready_o);
    got = decode_word(op, data);
    want_q.push_back(typed ? ans : got);
  endtask

  initial begin
    row_t        dir_rows [22];
    int unsigned n_rand;
    int unsigned n;
    dir_rows = '{
      '{zrbd_pkg::OpPull, 8'h00, 1'b1, zrbd_pkg::StNeed,   8'h00},
      '{zrbd_pkg::OpPush, 8'h49, 1'b1, zrbd_pkg::StAccept, 8'h00},
      '{zrbd_pkg::OpPush, 8'hFF, 1'b1, zrbd_pkg::StReject, 8'h00},
      '{zrbd_pkg::OpPush, 8'h00, 1'b1, zrbd_pkg::StReject, 8'h00},
      '{zrbd_pkg::OpPull, 8'hFF, 1'b0, zrbd_pkg::StByte,   8'h00},
      '{zrbd_pkg::OpPush, 8'h43, 1'b1, zrbd_pkg::StAccept, 8'h00},
      '{zrbd_pkg::OpPull, 8'h00, 1'b0, zrbd_pkg::StByte,   8'h00},
      '{zrbd_pkg::OpPush, 8'h45, 1'b1, zrbd_pkg::StAccept, 8'h00},
      '{zrbd_pkg::OpPull, 8'h00, 1'b0, zrbd_pkg::StByte,   8'h00},
      '{zrbd_pkg::OpPush, 8'h43, 1'b1, zrbd_pkg::StAccept, 8'h00},
      '{zrbd_pkg::OpPull, 8'h00, 1'b0, zrbd_pkg::StByte,   8'h00},
      '{zrbd_pkg::OpPush, 8'h4F, 1'b1, zrbd_pkg::StAccept, 8'h00},
      '{zrbd_pkg::OpPull, 8'h00, 1'b0, zrbd_pkg::StByte,   8'h00},
      '{zrbd_pkg::OpPush, 8'h4D, 1'b1, zrbd_pkg::StAccept, 8'h00},
      '{zrbd_pkg::OpPull, 8'h00, 1'b0, zrbd_pkg::StByte,   8'h00},
      '{zrbd_pkg::OpPush, 8'h50, 1'b1, zrbd_pkg::StAccept, 8'h00},
      '{zrbd_pkg::OpPull, 8'h00, 1'b0, zrbd_pkg::StByte,   8'h00},
      '{zrbd_pkg::OpPush, 8'h52, 1'b1, zrbd_pkg::StAccept, 8'h00},
      '{zrbd_pkg::OpPull, 8'h00, 1'b0, zrbd_pkg::StByte,   8'h00},
      '{zrbd_pkg::OpPush, 8'hFF, 1'b1, zrbd_pkg::StAccept, 8'h00},
      '{zrbd_pkg::OpPull, 8'h00, 1'b1, zrbd_pkg::StByte,   8'h11},
      '{zrbd_pkg::OpPull, 8'h00, 1'b0, zrbd_pkg::StByte,   8'h00}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      pace();
      put_word(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed,
               answer_t'({dir_rows[i].status, dir_rows[i].out}));
    end

    // The last pull stopped inside a short run: one count bit is still owed.
    code_bits.push_back(1'b1);
    out_bits = 4;

    n_rand = 0;
    while (n_rand < 400) begin
      pace();
      if (buf_left == 0 && $urandom_range(0, 11) != 0) begin
        put_word(zrbd_pkg::OpPush, next_stream_byte(), 1'b0, '0);
        n_rand++;
      end else if (buf_left != 0 && $urandom_range(0, 11) == 0) begin
        put_word(zrbd_pkg::OpPush, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        put_word(zrbd_pkg::OpPull, 8'($urandom_range(0, 255)), 1'b0, '0);
        n_rand++;
      end
    end

    // Pad with a literal so that the compressed stream ends on a byte boundary.
    n = (8 - (code_bits.size() + 38) % 8) % 8;
    add_bits(1, 4);
    add_bits(n, zrbd_pkg::LenW);
    repeat (n) add_bits($urandom_range(0, 1), 1);
    out_bits += n + 1;
    n = (8 - out_bits % 8) % 8 + 8 * $urandom_range(0, 2);
    if ($urandom_range(0, 1) != 0) n += $urandom_range(1, 7);
    add_bits(0, 5);
    add_bits(n, zrbd_pkg::CountW);

    while (!stream_done) begin
      pace();
      if (buf_left == 0 && code_bits.size() != 0) begin
        put_word(zrbd_pkg::OpPush, next_stream_byte(), 1'b0, '0);
      end else begin
        put_word(zrbd_pkg::OpPull, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
    pace();
    put_word(zrbd_pkg::OpPull, 8'h00, 1'b0, '0);
    pace();
    put_word(zrbd_pkg::OpPush, 8'($urandom_range(0, 255)), 1'b0, '0);
    pace();
    put_word(zrbd_pkg::OpPull, 8'hFF, 1'b0, '0);
    in_valid_i <= 1'b0;

    while (want_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_read++;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected word, status %0d byte %02h", $time, status_o, out_byte_o);
        errs++;
      end else begin
        head = want_q.pop_front();
        if (status_o !== head.status) begin
          $display("%0t: status expected %0d got %0d", $time, head.status, status_o);
          errs++;
        end
        if (out_byte_o !== head.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, head.data, out_byte_o);
          errs++;
        end
      end
    end
  end

  // The receiver switches among random stall patterns and holds off once
  // for a long stretch so that the input side backs up.
  initial begin
    logic        held;
    int unsigned mode;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && words_read >= 60) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      repeat (64) begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
